// ===== rtl/bcu_pkg.sv =====
// shared types for the binomial coefficient unit
// controller state, datapath command and status words; no dependencies
package bcu_pkg;

	localparam int unsigned CoefWidth = 63;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_OVCHK,
		ST_DIV,
		ST_UPDATE,
		ST_FINISH
	} bcu_state_t;

	typedef struct packed {
		logic load;
		logic mul_init;
		logic mul_step;
		logic div_init;
		logic div_step;
		logic acc_update;
		logic set_ovf;
		logic out_load;
	} bcu_cmd_t;

	typedef struct packed {
		logic iter_done;
		logic cnt_zero;
		logic prod_ovf;
	} bcu_status_t;

endpackage

// ===== rtl/bcu_if.sv =====
// channel interfaces of the binomial coefficient unit
// operand word in, coefficient word out; uses bcu_pkg for the result width
interface bcu_in_if #(parameter int unsigned OPERAND_WIDTH = 16);
	logic                            valid;
	logic                            ready;
	logic signed [OPERAND_WIDTH-1:0] n_value;
	logic signed [OPERAND_WIDTH-1:0] k_value;

	modport source (output valid, output n_value, output k_value, input ready);
	modport sink   (input valid, input n_value, input k_value, output ready);
endinterface

interface bcu_out_if import bcu_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CoefWidth-1:0] coefficient;
	logic                 overflow;

	modport source (output valid, output coefficient, output overflow, input ready);
	modport sink   (input valid, input coefficient, input overflow, output ready);
endinterface

// ===== rtl/bcu_datapath.sv =====
// datapath: operand normalisation, bit-serial multiply, restoring divide
// driven by bcu_ctrl through bcu_cmd_t; depends on bcu_pkg
module bcu_datapath import bcu_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = 16,
	parameter int unsigned RESULT_WIDTH  = 64
) (
	input  logic                            clk,
	input  logic signed [OPERAND_WIDTH-1:0] n_in,
	input  logic signed [OPERAND_WIDTH-1:0] k_in,
	input  bcu_cmd_t                        cmd,
	output bcu_status_t                     status,
	output logic [CoefWidth-1:0]            coefficient,
	output logic                            overflow
);
	localparam int unsigned OW   = OPERAND_WIDTH;
	localparam int unsigned AW   = RESULT_WIDTH - 1;
	localparam int unsigned PW   = AW + OW;
	localparam int unsigned MAXS = (AW > OW) ? AW : OW;
	localparam int unsigned CW   = $clog2(MAXS);

	logic [OW-1:0] n_mag, k_mag, hi, lo;
	logic [OW-1:0] k_q, span_q, i_q, fac_q;
	logic [AW-1:0] acc_q, dvd_q;
	logic [PW-1:0] prod_q;
	logic [OW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [OW:0]   trial;
	logic          qbit;

	// magnitudes; the most negative code maps to 2^(OW-1) without wrapping
	assign n_mag = n_in[OW-1] ? (~n_in + 1'b1) : n_in;
	assign k_mag = k_in[OW-1] ? (~k_in + 1'b1) : k_in;
	assign hi    = (n_mag < k_mag) ? k_mag : n_mag;
	assign lo    = (n_mag < k_mag) ? n_mag : k_mag;

	// divide step trial subtraction
	assign trial = {rem_q, dvd_q[AW-1]};
	assign qbit  = trial >= {1'b0, i_q};

	assign status.iter_done = i_q > span_q;
	assign status.cnt_zero  = cnt_q == '0;
	assign status.prod_ovf  = |prod_q[PW-1:AW];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q    <= lo;
			span_q <= hi - lo;
			i_q    <= {{(OW-1){1'b0}}, 1'b1};
			acc_q  <= {{(AW-1){1'b0}}, 1'b1};
			ovf_q  <= 1'b0;
		end
		// multiply, msb of the factor first
		if (cmd.mul_init) begin
			prod_q <= '0;
			fac_q  <= k_q + i_q;
			cnt_q  <= CW'(OW - 1);
		end
		if (cmd.mul_step) begin
			prod_q <= {prod_q[PW-2:0], 1'b0} + (fac_q[OW-1] ? {{OW{1'b0}}, acc_q} : '0);
			fac_q  <= {fac_q[OW-2:0], 1'b0};
			cnt_q  <= cnt_q - 1'b1;
		end
		// exact divide, one quotient bit a cycle
		if (cmd.div_init) begin
			dvd_q <= prod_q[AW-1:0];
			rem_q <= '0;
			cnt_q <= CW'(AW - 1);
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? OW'(trial - {1'b0, i_q}) : trial[OW-1:0];
			dvd_q <= {dvd_q[AW-2:0], qbit};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.acc_update) begin
			acc_q <= dvd_q;
			i_q   <= i_q + 1'b1;
		end
		if (cmd.set_ovf)
			ovf_q <= 1'b1;
		// result register
		if (cmd.out_load) begin
			coefficient <= ovf_q ? '0 : CoefWidth'(acc_q);
			overflow    <= ovf_q;
		end
	end

endmodule

// ===== rtl/bcu_ctrl.sv =====
// controller: sequences the multiply and divide passes per iteration
// and owns both handshakes; depends on bcu_pkg
module bcu_ctrl import bcu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  bcu_status_t status,
	output bcu_cmd_t    cmd
);
	bcu_state_t state_q, state_d;
	logic       out_valid_q;

	assign out_valid = out_valid_q;

	// state register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.iter_done)
					state_d = ST_FINISH;
				else begin
					cmd.mul_init = 1'b1;
					state_d      = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (status.cnt_zero)
					state_d = ST_OVCHK;
			end
			ST_OVCHK: begin
				if (status.prod_ovf) begin
					cmd.set_ovf = 1'b1;
					state_d     = ST_FINISH;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.cnt_zero)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.acc_update = 1'b1;
				state_d        = ST_CHECK;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// no second word taken while one is in work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("operand word accepted while busy");
	// a finished result lands in the output register
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result load lost");
	// divide pass ends in the accumulator update
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && status.cnt_zero) |=> state_q == ST_UPDATE)
		else $error("divide pass did not end in update");

endmodule

// ===== rtl/binomial_coefficient_unit.sv =====
// top level of the binomial coefficient unit: controller plus datapath
// depends on bcu_pkg, bcu_if, bcu_ctrl, bcu_datapath
//
//  channel   dir  payload                         handshake
//  in_chan   in   n_value, k_value (signed)       valid/ready
//  out_chan  out  coefficient[62:0], overflow     valid/ready
//
// one word at a time; each iteration of the multiplicative rule runs a check,
// a shift-add multiply pass, an overflow check, a restoring divide pass and
// an accumulator update, and a word takes span iterations, span being the
// larger magnitude less the smaller; an overflow cuts it short.
// reset returns the controller to idle with no result pending; a stalled
// output holds its word, and a new operand word may be taken meanwhile, but
// its result waits until the held word is taken.
module binomial_coefficient_unit import bcu_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = 16,
	parameter int unsigned RESULT_WIDTH  = 64
) (
	input logic clk,
	input logic arst_n,
	bcu_in_if.sink    in_chan,
	bcu_out_if.source out_chan
);
	bcu_cmd_t    cmd;
	bcu_status_t status;

	bcu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_chan.valid),
		.in_ready  (in_chan.ready),
		.out_valid (out_chan.valid),
		.out_ready (out_chan.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bcu_datapath #(
		.OPERAND_WIDTH (OPERAND_WIDTH),
		.RESULT_WIDTH  (RESULT_WIDTH)
	) u_dp (
		.clk         (clk),
		.n_in        (in_chan.n_value),
		.k_in        (in_chan.k_value),
		.cmd         (cmd),
		.status      (status),
		.coefficient (out_chan.coefficient),
		.overflow    (out_chan.overflow)
	);

endmodule

// ===== sim/tb_binomial_coefficient_unit.sv =====
// self-checking testbench for binomial_coefficient_unit: directed table then random operands
// depends on bcu_pkg, bcu_if and the rtl top level; predicts each coefficient word itself
`timescale 1ns / 100ps

module tb_binomial_coefficient_unit;
	import bcu_pkg::*;

	localparam int unsigned OpWidth = 16;
	localparam int unsigned ResWidth = 64;
	localparam int unsigned RandomWords = 1150;
	localparam int unsigned WatchdogLimit = 200000;
	localparam int unsigned LongHold = 3000;
	localparam longint unsigned ProductLimit = (64'd1 << (ResWidth - 1)) - 64'd1;

	typedef struct {
		logic [CoefWidth-1:0] coefficient;
		logic                 overflow;
	} coef_word_t;

	typedef struct {
		int         n;
		int         k;
		bit         typed;
		coef_word_t word;
	} table_row_t;

	logic clk;
	logic arst_n;

	bcu_in_if #(.OPERAND_WIDTH(OpWidth)) in_if ();
	bcu_out_if out_if ();

	binomial_coefficient_unit #(
		.OPERAND_WIDTH(OpWidth),
		.RESULT_WIDTH (ResWidth)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_chan (in_if),
		.out_chan(out_if)
	);

	coef_word_t  pending_coefs[$];
	table_row_t  directed_rows[$];
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int unsigned coefs_taken = 0;
	int unsigned rows_taken = 0;

	// clock, 8 ns period
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// magnitude of a two's complement operand, most negative value kept exact
	function automatic longint unsigned operand_mag(logic signed [OpWidth-1:0] raw);
		longint signed v;
		v = raw;
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// multiplicative rule with overflow stop
	function automatic coef_word_t binomial_of(logic signed [OpWidth-1:0] n_raw,
			logic signed [OpWidth-1:0] k_raw);
		longint unsigned hi, lo, acc, factor, tmp;
		coef_word_t      res;
		hi = operand_mag(n_raw);
		lo = operand_mag(k_raw);
		acc = 1;
		res.overflow = 1'b0;
		if (hi < lo) begin
			tmp = hi;
			hi = lo;
			lo = tmp;
		end
		for (longint unsigned i = 1; i <= hi - lo; i++) begin
			factor = lo + i;
			if (acc > ProductLimit / factor) begin
				res.overflow = 1'b1;
				break;
			end
			acc = (acc * factor) / i;
		end
		res.coefficient = res.overflow ? '0 : acc[CoefWidth-1:0];
		return res;
	endfunction

	// signed operand of a given magnitude, sign picked at random
	function automatic logic signed [OpWidth-1:0] signed_of(int unsigned mag);
		if (mag == 32768)
			return {1'b1, {(OpWidth-1){1'b0}}};
		if (mag != 0 && $urandom_range(1, 0))
			return -$signed(mag[OpWidth-1:0]);
		return mag[OpWidth-1:0];
	endfunction

	function automatic table_row_t row(int n, int k, bit typed = 0,
			longint unsigned coef = 0, bit ovf = 0);
		table_row_t r;
		r.n = n;
		r.k = k;
		r.typed = typed;
		r.word.coefficient = coef[CoefWidth-1:0];
		r.word.overflow = ovf;
		return r;
	endfunction

	// offer one operand word after a random gap and hold it until taken
	task automatic send_word(logic signed [OpWidth-1:0] n_op, logic signed [OpWidth-1:0] k_op);
		int unsigned gap;
		gap = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 5) : $urandom_range(2, 0);
		if ($urandom_range(3, 0) == 0)
			gap = 0;
		if (gap != 0)
			in_if.valid <= 1'b0;
		repeat (gap)
			@(posedge clk);
		in_if.valid <= 1'b1;
		in_if.n_value <= n_op;
		in_if.k_value <= k_op;
		do
			@(posedge clk);
		while (!in_if.ready);
	endtask

	// operand word accepted: queue its expected coefficient
	always @(posedge clk) begin
		if (in_if.valid && in_if.ready) begin
			if (rows_taken < directed_rows.size() && directed_rows[rows_taken].typed &&
					directed_rows[rows_taken].n == in_if.n_value &&
					directed_rows[rows_taken].k == in_if.k_value)
				pending_coefs.push_back(directed_rows[rows_taken].word);
			else
				pending_coefs.push_back(binomial_of(in_if.n_value, in_if.k_value));
			if (rows_taken < directed_rows.size())
				rows_taken++;
		end
	end

	// coefficient word accepted: compare with the oldest expectation
	always @(posedge clk) begin
		coef_word_t want;
		if (out_if.valid && out_if.ready) begin
			coefs_taken++;
			if (pending_coefs.size() == 0) begin
				$error("coefficient word with nothing expected");
				mismatches++;
			end else begin
				want = pending_coefs.pop_front();
				if (out_if.coefficient !== want.coefficient) begin
					$error("coefficient: expected %0d, got %0d", want.coefficient,
						out_if.coefficient);
					mismatches++;
				end
				if (out_if.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, out_if.overflow);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// receiver: random ready runs, one long hold-off part way through
	initial begin
		int unsigned run;
		bit          long_done;
		long_done = 0;
		out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_done && coefs_taken >= 300) begin
				long_done = 1;
				out_if.ready <= 1'b0;
				repeat (LongHold - 1)
					@(posedge clk);
			end else if ($urandom_range(2, 0) != 0) begin
				run = $urandom_range(20, 1);
				out_if.ready <= 1'b1;
				repeat (run - 1)
					@(posedge clk);
			end else begin
				run = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
				out_if.ready <= 1'b0;
				repeat (run - 1)
					@(posedge clk);
			end
		end
	end

	// sender: directed table, then random operands
	initial begin
		int unsigned lo_mag, span, hi_mag, tmp;
		logic signed [OpWidth-1:0] n_op, k_op;
		in_if.valid = 1'b0;
		in_if.n_value = '0;
		in_if.k_value = '0;
		arst_n = 1'b0;

		// equal operands, zeros, extremes, overflow, then rows predicted by binomial_of
		directed_rows.push_back(row(0, 0, 1, 1));
		directed_rows.push_back(row(32767, 32767, 1, 1));
		directed_rows.push_back(row(-32768, -32768, 1, 1));
		directed_rows.push_back(row(-32768, 32767, 1, 32768));
		directed_rows.push_back(row(32767, -32768, 1, 32768));
		directed_rows.push_back(row(5, 0, 1, 1));
		directed_rows.push_back(row(0, -5, 1, 1));
		directed_rows.push_back(row(1, 0, 1, 1));
		directed_rows.push_back(row(-1, 1, 1, 1));
		directed_rows.push_back(row(-7, 7, 1, 1));
		directed_rows.push_back(row(64, -1, 1, 64));
		directed_rows.push_back(row(-32768, 16384, 1, 0, 1));
		directed_rows.push_back(row(-16384, 32767, 1, 0, 1));
		directed_rows.push_back(row(10, 3));
		directed_rows.push_back(row(3, 10));
		directed_rows.push_back(row(-10, -4));
		directed_rows.push_back(row(62, 31));
		directed_rows.push_back(row(-66, 33));
		directed_rows.push_back(row(70, -35));
		directed_rows.push_back(row(20000, 19990));
		directed_rows.push_back(row(100, 2));
		directed_rows.push_back(row(-21845, 10922));

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fork
			begin
				for (int i = 0; i < directed_rows.size(); i++)
					send_word(OpWidth'(directed_rows[i].n), OpWidth'(directed_rows[i].k));
				for (int i = 0; i < RandomWords; i++) begin
					if ($urandom_range(19, 0) == 0) begin
						// noise: full-range operands, kept clear of very slow small-k runs
						do begin
							n_op = OpWidth'($urandom);
							k_op = OpWidth'($urandom);
						end while (operand_mag(n_op) < 64 || operand_mag(k_op) < 64);
					end else begin
						lo_mag = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 0)
							: $urandom_range(32768, 0);
						span = ($urandom_range(29, 0) == 0) ? $urandom_range(60, 13)
							: $urandom_range(12, 0);
						hi_mag = (lo_mag + span > 32768) ? 32768 : lo_mag + span;
						if ($urandom_range(1, 0)) begin
							tmp = hi_mag;
							hi_mag = lo_mag;
							lo_mag = tmp;
						end
						n_op = signed_of(hi_mag);
						k_op = signed_of(lo_mag);
					end
					send_word(n_op, k_op);
				end
				in_if.valid <= 1'b0;
				while (pending_coefs.size() != 0)
					@(posedge clk);
				repeat (200)
					@(posedge clk);
				if (mismatches == 0 && pending_coefs.size() == 0)
					$display("All tests passed");
				else
					$display("Some tests failed");
				$finish;
			end
			begin
				while (idle_cycles < WatchdogLimit)
					@(posedge clk);
				$display("Some tests failed");
				$finish;
			end
		join_any
	end

endmodule

// ===== binomial_coefficient_unit.f =====
rtl/bcu_pkg.sv
rtl/bcu_if.sv
rtl/bcu_datapath.sv
rtl/bcu_ctrl.sv
rtl/binomial_coefficient_unit.sv
sim/tb_binomial_coefficient_unit.sv
